FILE: sv/obf_pkg.sv
// Package: widths, constants and stage types for the orthonormal basis core.
package obf_pkg;

   localparam int FRAC_BITS = 16;
   localparam int W         = FRAC_BITS + 2;   // component width
   localparam int SW        = 2 * W;           // sum of squares width
   localparam int SREMW     = W + 3;           // square root remainder width
   localparam int NW        = W + FRAC_BITS;   // dividend / quotient width
   localparam int DREMW     = W + 1;           // divider remainder width
   localparam int SQRT_CELLS = SW / 2;
   localparam int DIV_CELLS  = NW;

   localparam logic [W-1:0] ONE_FX = W'(1) << FRAC_BITS;

   // Data that rides along with every item down the chain
   typedef struct packed {
      logic                sel;     // 1: |x| > |y|, perp = (-z, 0, x)
      logic                degen;
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
      logic signed [W-1:0] z;
      logic                neg_a;
      logic                neg_b;
   } side_type;

   typedef struct packed {
      side_type           side;
      logic [SW-1:0]      s;
      logic [SREMW-1:0]   rem;
      logic [W-1:0]       root;
      logic [NW-1:0]      na;
      logic [NW-1:0]      nb;
   } sqrt_stage_type;

   typedef struct packed {
      side_type           side;
      logic [W-1:0]       r;
      logic [NW-1:0]      na;
      logic [NW-1:0]      nb;
      logic [DREMW-1:0]   rema;
      logic [DREMW-1:0]   remb;
      logic [NW-1:0]      qa;
      logic [NW-1:0]      qb;
   } div_stage_type;

endpackage

FILE: sv/obf_if.sv
// Interfaces: request and response channels of the orthonormal basis core.
interface obf_req_if;
   logic                        valid;
   logic                        ready;
   logic signed [obf_pkg::W-1:0] in_x;
   logic signed [obf_pkg::W-1:0] in_y;
   logic signed [obf_pkg::W-1:0] in_z;

   modport source (output valid, in_x, in_y, in_z, input ready);
   modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

interface obf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic signed [obf_pkg::W-1:0] perp_x;
   logic signed [obf_pkg::W-1:0] perp_y;
   logic signed [obf_pkg::W-1:0] perp_z;
   logic signed [obf_pkg::W-1:0] third_x;
   logic signed [obf_pkg::W-1:0] third_y;
   logic signed [obf_pkg::W-1:0] third_z;
   logic                        degenerate;

   modport source (output valid, perp_x, perp_y, perp_z, third_x, third_y, third_z,
                   degenerate, input ready);
   modport sink   (input valid, perp_x, perp_y, perp_z, third_x, third_y, third_z,
                   degenerate, output ready);
endinterface

FILE: sv/obf_sqrt_cell.sv
// Square root cell: one result bit of the digit-by-digit integer square root.
module obf_sqrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    valid_in,
   input  obf_pkg::sqrt_stage_type stage_in,
   output logic                    valid_out,
   output obf_pkg::sqrt_stage_type stage_out
);

   logic                        valid_ff;
   obf_pkg::sqrt_stage_type     stage_ff, stage_in_nx;
   logic [obf_pkg::SREMW-1:0]   rem_sh, trial;

   always_comb begin
      rem_sh = {stage_in.rem[obf_pkg::SREMW-3:0], stage_in.s[obf_pkg::SW-1 -: 2]};
      trial  = obf_pkg::SREMW'({stage_in.root, 2'b01});
      stage_in_nx   = stage_in;
      stage_in_nx.s = stage_in.s << 2;
      if (rem_sh >= trial) begin
         stage_in_nx.rem  = rem_sh - trial;
         stage_in_nx.root = {stage_in.root[obf_pkg::W-2:0], 1'b1};
      end else begin
         stage_in_nx.rem  = rem_sh;
         stage_in_nx.root = {stage_in.root[obf_pkg::W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in_nx;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

FILE: sv/obf_div_cell.sv
// Divider cell: one quotient bit of two restoring divisions by a shared divisor.
module obf_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   valid_in,
   input  obf_pkg::div_stage_type stage_in,
   output logic                   valid_out,
   output obf_pkg::div_stage_type stage_out
);

   logic                      valid_ff;
   obf_pkg::div_stage_type    stage_ff, stage_in_nx;
   logic [obf_pkg::DREMW-1:0] rema_sh, remb_sh, dvs;

   always_comb begin
      dvs     = {1'b0, stage_in.r};
      rema_sh = {stage_in.rema[obf_pkg::DREMW-2:0], stage_in.na[obf_pkg::NW-1]};
      remb_sh = {stage_in.remb[obf_pkg::DREMW-2:0], stage_in.nb[obf_pkg::NW-1]};
      stage_in_nx    = stage_in;
      stage_in_nx.na = stage_in.na << 1;
      stage_in_nx.nb = stage_in.nb << 1;
      if (rema_sh >= dvs) begin
         stage_in_nx.rema = rema_sh - dvs;
         stage_in_nx.qa   = {stage_in.qa[obf_pkg::NW-2:0], 1'b1};
      end else begin
         stage_in_nx.rema = rema_sh;
         stage_in_nx.qa   = {stage_in.qa[obf_pkg::NW-2:0], 1'b0};
      end
      if (remb_sh >= dvs) begin
         stage_in_nx.remb = remb_sh - dvs;
         stage_in_nx.qb   = {stage_in.qb[obf_pkg::NW-2:0], 1'b1};
      end else begin
         stage_in_nx.remb = remb_sh;
         stage_in_nx.qb   = {stage_in.qb[obf_pkg::NW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in_nx;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

FILE: sv/orthonormal_basis_from_vector_core.sv
// Top level: pipelined orthonormal basis from one Q1.16 vector.
//
// Takes one vector (in_x, in_y, in_z) per beat and returns the unit vector
// perpendicular to it (perp_*) and the cross product v x perp (third_*), all
// signed Q1.16 and saturated to +/-1.0. The perpendicular is (-z,0,x) when
// |x| > |y| and (0,z,-y) otherwise (a tie takes the second form), divided by
// floor(sqrt) of the matching sum of squares, truncated toward zero. A zero
// sum of squares gives all-zero vectors with degenerate set. Throughput is one
// beat per cycle. The chain is 2 front stages (squares, branch select and
// sum), a chain of 18 square root cells (one root bit each), a chain of 34
// divider cells (one quotient bit of both nonzero perpendicular components
// each), then saturation, products and the cross product reduce.
// The whole chain moves as one: while a result waits on rsp, nothing advances
// and req_bus.ready is low. Reset clears only the valid bits.
module orthonormal_basis_from_vector_core (
   input  logic     clock,
   input  logic     reset,
   obf_req_if.sink  req_bus,
   obf_rsp_if.source rsp_bus
);

   localparam int W  = obf_pkg::W;
   localparam int F  = obf_pkg::FRAC_BITS;

   logic en;
   logic out_valid_ff;

   // chain advances unless a result is parked on the output
   assign en            = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   // ---------------- stage A: magnitudes and squares ----------------
   logic                a_valid_ff;
   logic signed [W-1:0] a_x_ff, a_y_ff, a_z_ff;
   logic [W-1:0]        a_mx_ff, a_my_ff, a_mz_ff;
   logic [2*W-1:0]      a_sqx_ff, a_sqy_ff, a_sqz_ff;
   logic [W-1:0]        mx_in, my_in, mz_in;

   always_comb begin
      mx_in = req_bus.in_x[W-1] ? W'(-req_bus.in_x) : W'(req_bus.in_x);
      my_in = req_bus.in_y[W-1] ? W'(-req_bus.in_y) : W'(req_bus.in_y);
      mz_in = req_bus.in_z[W-1] ? W'(-req_bus.in_z) : W'(req_bus.in_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_x_ff   <= req_bus.in_x;
         a_y_ff   <= req_bus.in_y;
         a_z_ff   <= req_bus.in_z;
         a_mx_ff  <= mx_in;
         a_my_ff  <= my_in;
         a_mz_ff  <= mz_in;
         a_sqx_ff <= mx_in * mx_in;
         a_sqy_ff <= my_in * my_in;
         a_sqz_ff <= mz_in * mz_in;
      end
   end

   // ---------------- stage B: branch, sum, dividends ----------------
   logic                    b_valid_ff;
   obf_pkg::sqrt_stage_type b_stage_ff, b_stage_in;
   logic                    sel_in;

   always_comb begin
      sel_in = a_mx_ff > a_my_ff;
      b_stage_in            = '0;
      b_stage_in.side.sel   = sel_in;
      b_stage_in.side.x     = a_x_ff;
      b_stage_in.side.y     = a_y_ff;
      b_stage_in.side.z     = a_z_ff;
      // lane a: -z or z, lane b: x or -y
      b_stage_in.side.neg_a = sel_in ? (!a_z_ff[W-1] && (a_z_ff != '0)) : a_z_ff[W-1];
      b_stage_in.side.neg_b = sel_in ? a_x_ff[W-1] : (!a_y_ff[W-1] && (a_y_ff != '0));
      b_stage_in.s          = sel_in ? (a_sqx_ff + a_sqz_ff) : (a_sqy_ff + a_sqz_ff);
      b_stage_in.side.degen = (b_stage_in.s == '0);
      b_stage_in.na         = {a_mz_ff, F'(0)};
      b_stage_in.nb         = {(sel_in ? a_mx_ff : a_my_ff), F'(0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_stage_ff <= b_stage_in;
      end
   end

   // ---------------- square root chain ----------------
   logic                    sq_valid [obf_pkg::SQRT_CELLS+1];
   obf_pkg::sqrt_stage_type sq_stage [obf_pkg::SQRT_CELLS+1];

   assign sq_valid[0] = b_valid_ff;
   assign sq_stage[0] = b_stage_ff;

   for (genvar i = 0; i < obf_pkg::SQRT_CELLS; i++) begin : g_sqrt
      obf_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (sq_valid[i]),
         .stage_in  (sq_stage[i]),
         .valid_out (sq_valid[i+1]),
         .stage_out (sq_stage[i+1])
      );
   end

   // ---------------- divider chain ----------------
   logic                   dv_valid [obf_pkg::DIV_CELLS+1];
   obf_pkg::div_stage_type dv_stage [obf_pkg::DIV_CELLS+1];

   always_comb begin
      dv_valid[0]      = sq_valid[obf_pkg::SQRT_CELLS];
      dv_stage[0]      = '0;
      dv_stage[0].side = sq_stage[obf_pkg::SQRT_CELLS].side;
      dv_stage[0].r    = sq_stage[obf_pkg::SQRT_CELLS].root;
      dv_stage[0].na   = sq_stage[obf_pkg::SQRT_CELLS].na;
      dv_stage[0].nb   = sq_stage[obf_pkg::SQRT_CELLS].nb;
   end

   for (genvar i = 0; i < obf_pkg::DIV_CELLS; i++) begin : g_div
      obf_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .valid_in  (dv_valid[i]),
         .stage_in  (dv_stage[i]),
         .valid_out (dv_valid[i+1]),
         .stage_out (dv_stage[i+1])
      );
   end

   // ---------------- stage P: saturate quotients, place perp ----------------
   obf_pkg::div_stage_type dv_last;
   logic                   p_valid_ff;
   obf_pkg::side_type      p_side_ff;
   logic signed [W-1:0]    p_px_ff, p_py_ff, p_pz_ff;
   logic [W-1:0]           qa_sat, qb_sat;
   logic signed [W-1:0]    pa_in, pb_in;

   assign dv_last = dv_stage[obf_pkg::DIV_CELLS];

   always_comb begin
      qa_sat = (dv_last.qa > obf_pkg::NW'(obf_pkg::ONE_FX)) ? obf_pkg::ONE_FX
                                                             : dv_last.qa[W-1:0];
      qb_sat = (dv_last.qb > obf_pkg::NW'(obf_pkg::ONE_FX)) ? obf_pkg::ONE_FX
                                                             : dv_last.qb[W-1:0];
      pa_in  = dv_last.side.neg_a ? -$signed(qa_sat) : $signed(qa_sat);
      pb_in  = dv_last.side.neg_b ? -$signed(qb_sat) : $signed(qb_sat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (en) begin
         p_valid_ff <= dv_valid[obf_pkg::DIV_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_side_ff <= dv_last.side;
         p_px_ff   <= dv_last.side.sel ? pa_in : '0;
         p_py_ff   <= dv_last.side.sel ? '0 : pa_in;
         p_pz_ff   <= pb_in;
      end
   end

   // ---------------- stage M: cross product terms ----------------
   logic                  m_valid_ff;
   obf_pkg::side_type     m_side_ff;
   logic signed [W-1:0]   m_px_ff, m_py_ff, m_pz_ff;
   logic signed [2*W-1:0] m_ypz_ff, m_zpy_ff, m_zpx_ff, m_xpz_ff, m_xpy_ff, m_ypx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_side_ff <= p_side_ff;
         m_px_ff   <= p_px_ff;
         m_py_ff   <= p_py_ff;
         m_pz_ff   <= p_pz_ff;
         m_ypz_ff  <= p_side_ff.y * p_pz_ff;
         m_zpy_ff  <= p_side_ff.z * p_py_ff;
         m_zpx_ff  <= p_side_ff.z * p_px_ff;
         m_xpz_ff  <= p_side_ff.x * p_pz_ff;
         m_xpy_ff  <= p_side_ff.x * p_py_ff;
         m_ypx_ff  <= p_side_ff.y * p_px_ff;
      end
   end

   // ---------------- stage R: reduce, saturate, output register ----------------
   // (p1 - p2) >> FRAC_BITS on the magnitude, clamped to one
   function automatic logic signed [W-1:0] reduce_diff(
      input logic signed [2*W-1:0] p1,
      input logic signed [2*W-1:0] p2
   );
      logic signed [2*W:0] d;
      logic [2*W:0]        m;
      logic [2*W:0]        sh;
      logic [W-1:0]        r;
      d  = {p1[2*W-1], p1} - {p2[2*W-1], p2};
      m  = d[2*W] ? (2*W+1)'(-d) : d;
      sh = m >> F;
      r  = (sh > (2*W+1)'(obf_pkg::ONE_FX)) ? obf_pkg::ONE_FX : sh[W-1:0];
      return d[2*W] ? -$signed(r) : $signed(r);
   endfunction

   logic signed [W-1:0] r_px_ff, r_py_ff, r_pz_ff, r_tx_ff, r_ty_ff, r_tz_ff;
   logic                r_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_degen_ff <= m_side_ff.degen;
         if (m_side_ff.degen) begin
            r_px_ff <= '0;
            r_py_ff <= '0;
            r_pz_ff <= '0;
            r_tx_ff <= '0;
            r_ty_ff <= '0;
            r_tz_ff <= '0;
         end else begin
            r_px_ff <= m_px_ff;
            r_py_ff <= m_py_ff;
            r_pz_ff <= m_pz_ff;
            r_tx_ff <= reduce_diff(m_ypz_ff, m_zpy_ff);
            r_ty_ff <= reduce_diff(m_zpx_ff, m_xpz_ff);
            r_tz_ff <= reduce_diff(m_xpy_ff, m_ypx_ff);
         end
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.perp_x     = r_px_ff;
   assign rsp_bus.perp_y     = r_py_ff;
   assign rsp_bus.perp_z     = r_pz_ff;
   assign rsp_bus.third_x    = r_tx_ff;
   assign rsp_bus.third_y    = r_ty_ff;
   assign rsp_bus.third_z    = r_tz_ff;
   assign rsp_bus.degenerate = r_degen_ff;

`ifndef SYNTHESIS
   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && r_degen_ff) |-> (r_px_ff == '0 && r_py_ff == '0 && r_pz_ff == '0
         && r_tx_ff == '0 && r_ty_ff == '0 && r_tz_ff == '0))
      else $error("degenerate result with nonzero vector");

   a_one_perp_zero : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !r_degen_ff) |-> (r_px_ff == '0 || r_py_ff == '0))
      else $error("perpendicular has both x and y nonzero");

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> a_valid_ff)
      else $error("accepted beat lost at chain entry");
`endif

endmodule
